>>> rtl/haplotype_variant_applier_macros.svh
// ----------------------------------------------------------------------------
// Haplotype variant applier assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HAPLOTYPE_VARIANT_APPLIER_MACROS_SVH
`define HAPLOTYPE_VARIANT_APPLIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HVA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hva assertion failed");

// Next-cycle implication, disabled during reset.
`define HVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hva assertion failed");

`endif

>>> rtl/hva_pkg.sv
// ----------------------------------------------------------------------------
// hva_pkg
// Types and constants shared by the haplotype variant applier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hva_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int LEN_BITS           = 32;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [7:0] WRAP_WIDTH_RESET = 8'd70;
   localparam logic [7:0] NEWLINE_SYM      = 8'd10;

   // register index 0: symbols per output line
   localparam logic CSR_IDX_WRAP_WIDTH = 1'b0;

   // result queue
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_REF = 2'd0,
      KIND_SNP = 2'd1,
      KIND_HDR = 2'd2,
      KIND_INS = 2'd3
   } hva_kind_type;

   typedef struct packed {
      hva_kind_type         kind;
      logic [7:0]           base;
      logic [7:0]           alt_base;
      logic                 present;
      logic                 same_pos;
      logic [LEN_BITS-1:0]  del_len;
      logic [LEN_BITS-1:0]  ins_len;
      logic                 double_ins;
      logic                 is_insertion;
      logic                 clear_ins;
      logic                 char_last;
   } hva_req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } hva_rsp_type;

   // up to two result beats produced by one item
   typedef struct packed {
      logic        push0;
      logic        push1;
      hva_rsp_type beat0;
      hva_rsp_type beat1;
   } hva_push_type;

endpackage

>>> rtl/hva_core.sv
// ----------------------------------------------------------------------------
// hva_core
// Per-item state update: deletion and insertion counters, line counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hva_core #(
   parameter int COUNT_BITS = hva_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  hva_pkg::hva_req_type item,
   input  logic [7:0]           wrap_width,
   output hva_pkg::hva_push_type push
);
   import hva_pkg::*;

   localparam logic [63:0] CntMax = 64'({COUNT_BITS{1'b1}});

   logic [COUNT_BITS-1:0] delete_count_ff, delete_count_in;
   logic [COUNT_BITS-1:0] insert_skip_ff, insert_skip_in;
   logic [COUNT_BITS-1:0] saved_insert_ff, saved_insert_in;
   logic [COUNT_BITS-1:0] pending_len_ff, pending_len_in;
   logic                  overlap_ff, overlap_in;
   logic [7:0]            line_count_ff, line_count_in;

   logic [63:0]           del_wide, ins_wide;
   logic [COUNT_BITS-1:0] del_sat, ins_sat;
   logic                  use_ref;
   logic [7:0]            ref_sym;
   logic                  emit;
   logic [7:0]            sym;
   logic [7:0]            line_inc;
   logic                  newline;

   // saturate loaded lengths to the counter width
   assign del_wide = 64'(item.del_len);
   assign ins_wide = 64'(item.ins_len);
   assign del_sat  = (del_wide > CntMax) ? COUNT_BITS'(CntMax) : COUNT_BITS'(del_wide);
   assign ins_sat  = (ins_wide > CntMax) ? COUNT_BITS'(CntMax) : COUNT_BITS'(ins_wide);

   always_comb begin
      delete_count_in = delete_count_ff;
      insert_skip_in  = insert_skip_ff;
      saved_insert_in = saved_insert_ff;
      pending_len_in  = pending_len_ff;
      overlap_in      = overlap_ff;
      use_ref         = 1'b0;
      ref_sym         = item.base;
      emit            = 1'b0;
      sym             = item.base;

      case (item.kind)
         KIND_REF: begin
            use_ref = 1'b1;
         end
         KIND_SNP: begin
            use_ref = 1'b1;
            ref_sym = item.present ? item.alt_base : item.base;
         end
         KIND_HDR: begin
            use_ref = !item.same_pos;
         end
         default: begin
            use_ref = 1'b0;
         end
      endcase

      if (use_ref) begin
         if (delete_count_ff != '0) begin
            delete_count_in = delete_count_ff - 1'b1;
         end else begin
            emit = 1'b1;
            sym  = ref_sym;
         end
      end

      if (item.kind == KIND_HDR) begin
         if (item.present) begin
            if (del_sat > delete_count_in) begin
               delete_count_in = del_sat;
            end
            if (item.is_insertion) begin
               overlap_in      = item.double_ins;
               saved_insert_in = item.double_ins ? insert_skip_ff : '0;
               pending_len_in  = ins_sat;
               // empty insertion: no character follows, close it now
               if (ins_sat == '0) begin
                  insert_skip_in = saved_insert_in;
               end
            end
         end else if (item.clear_ins) begin
            insert_skip_in = '0;
         end
      end

      if (item.kind == KIND_INS) begin
         if (overlap_ff && (insert_skip_ff != '0)) begin
            insert_skip_in = insert_skip_ff - 1'b1;
         end else begin
            emit = 1'b1;
            sym  = item.base;
         end
         if (item.char_last) begin
            insert_skip_in = (pending_len_ff > saved_insert_ff) ? pending_len_ff
                                                                : saved_insert_ff;
         end
      end
   end

   // line wrap
   assign line_inc      = line_count_ff + 8'd1;
   assign newline       = emit && (line_inc >= wrap_width);
   assign line_count_in = emit ? (newline ? 8'd0 : line_inc) : line_count_ff;

   always_comb begin
      push.push0        = go && emit;
      push.push1        = go && newline;
      push.beat0.symbol = sym;
      push.beat0.last   = !newline;
      push.beat1.symbol = NEWLINE_SYM;
      push.beat1.last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delete_count_ff <= '0;
         insert_skip_ff  <= '0;
         saved_insert_ff <= '0;
         pending_len_ff  <= '0;
         overlap_ff      <= 1'b0;
         line_count_ff   <= '0;
      end else if (go) begin
         delete_count_ff <= delete_count_in;
         insert_skip_ff  <= insert_skip_in;
         saved_insert_ff <= saved_insert_in;
         pending_len_ff  <= pending_len_in;
         overlap_ff      <= overlap_in;
         line_count_ff   <= line_count_in;
      end
   end

endmodule

>>> rtl/hva_outq.sv
// ----------------------------------------------------------------------------
// hva_outq
// Small result queue: takes up to two beats per cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hva_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  hva_pkg::hva_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hva_pkg::hva_rsp_type  rsp_payload
);
   import hva_pkg::*;

   hva_rsp_type               entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_BITS-1:0]  count_ff, count_in;
   logic                      pop;
   logic [OUTQ_PTR_BITS-1:0]  wr_ptr_next;
   logic [1:0]                n_push;

   assign pop         = (count_ff != '0) && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign n_push      = {1'b0, push.push0} + {1'b0, push.push1};
   // room for a full pair of beats
   assign room        = count_ff <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2);

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + OUTQ_PTR_BITS'(n_push);
   assign rd_ptr_in = rd_ptr_ff + OUTQ_PTR_BITS'(pop);
   assign count_in  = count_ff + OUTQ_CNT_BITS'(n_push) - OUTQ_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[wr_ptr_ff] <= push.beat0;
      end
      if (push.push1) begin
         entry_ff[wr_ptr_next] <= push.beat1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/haplotype_variant_applier.sv
// ----------------------------------------------------------------------------
// haplotype_variant_applier
// Rebuilds one haplotype's sequence from reference bases and variant events.
// ----------------------------------------------------------------------------
// Path: input register, then result queue. Throughput: one item per cycle while the
//   queue has room for a pair of beats; an item that ends a line yields two beats
//   (symbol, newline), so the rsp side sets the sustained rate at one beat/cycle.
// Reset: synchronous, active high; clears all counters, empties the result
//   queue and loads the line wrap width with 70. No clearing pass is needed.
`timescale 1ns / 1ps

module haplotype_variant_applier #(
   parameter int COUNT_BITS = hva_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // item channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hva_pkg::hva_req_type               req_payload,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hva_pkg::hva_rsp_type               rsp_payload,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hva_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hva_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hva_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import hva_pkg::*;

   // Input register: holds one beat ahead of the core. It drains into the
   // core whenever the result queue can absorb a worst-case pair of beats,
   // so a new beat lands in the same cycle the old one moves on.
   logic        in_valid_ff, in_valid_in;
   hva_req_type in_item_ff;
   logic        room;
   logic        go;

   // line wrap width register
   logic [7:0]  wrap_width_ff, wrap_width_in;
   logic        csr_wr;
   logic        csr_hit;

   hva_push_type push;

   assign go          = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_payload;
      end
   end

   // Register port: one register at word 0; pready tied high.
   assign csr_pready    = 1'b1;
   assign csr_hit       = csr_paddr[2] == CSR_IDX_WRAP_WIDTH;
   assign csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wrap_width_in = (csr_wr && csr_hit) ? csr_pwdata[7:0] : wrap_width_ff;
   assign csr_prdata    = csr_hit ? CSR_DATA_BITS'(wrap_width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_width_ff <= WRAP_WIDTH_RESET;
      end else begin
         wrap_width_ff <= wrap_width_in;
      end
   end

   // Counter state and the per-item decision.
   hva_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .item       (in_item_ff),
      .wrap_width (wrap_width_ff),
      .push       (push)
   );

   // Result queue decouples the pair of beats from the rsp handshake.
   hva_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/hva_checker.sv
// ----------------------------------------------------------------------------
// hva_checker
// Port-level checks on the haplotype variant applier, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "haplotype_variant_applier_macros.svh"

module hva_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input hva_pkg::hva_rsp_type rsp_payload
);
   import hva_pkg::*;

   logic rsp_held;
   logic rsp_take;
   logic newline_head;

   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_take     = rsp_valid && !rsp_stall;
   assign newline_head = rsp_valid && rsp_payload.last && (rsp_payload.symbol == NEWLINE_SYM);

   // a stalled result beat holds
   `HVA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // a beat that is not last is a symbol with its newline queued right behind
   `HVA_ASSERT_NEXT(a_newline_follows, clock, reset, rsp_take && !rsp_payload.last, newline_head)

   // nothing comes out straight after reset
   `HVA_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

   // stall on the item side only while the block holds an item of its own
   `HVA_ASSERT_NEXT(a_stall_needs_beat, clock, reset, !req_stall && !req_valid, !req_stall)

endmodule

bind haplotype_variant_applier hva_checker u_hva_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Haplotype variant applier testbench
// Feeds reference bases, SNP sites, indel headers and inserted characters,
// covering every item kind and the deletion and insertion-overlap corner
// cases, then random well-formed variant groups mixed with noise, under
// several line widths. A scoreboard keeps its own copy of the deletion,
// insertion-skip and line counters and checks every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import hva_pkg::*;

   // the wrap width is register 0, so it sits at byte address 0
   localparam logic [CSR_ADDR_BITS-1:0] WRAP_WIDTH_ADDR =
      CSR_ADDR_BITS'(4 * CSR_IDX_WRAP_WIDTH);
   localparam int                       CNT_W           = COUNT_BITS_DEFAULT;

   // -------------------------------------------------------------------------
   // Sequence scoreboard: rebuilds the haplotype and holds the beats to come
   // -------------------------------------------------------------------------
   class hva_scoreboard;
      hva_rsp_type       expected_q[$];
      logic [7:0]        wrap_width;
      logic [CNT_W-1:0]  delete_count;
      logic [CNT_W-1:0]  insert_skip;
      logic [CNT_W-1:0]  saved_insert;
      logic [CNT_W-1:0]  pending_ins_len;
      logic              overlap_mode;
      logic [7:0]        line_count;
      logic [7:0]        staged[2];
      int                n_staged;
      int                errors;

      function new();
         wrap_width      = WRAP_WIDTH_RESET;
         delete_count    = '0;
         insert_skip     = '0;
         saved_insert    = '0;
         pending_ins_len = '0;
         overlap_mode    = 1'b0;
         line_count      = '0;
         errors          = 0;
      endfunction

      function void set_width(logic [7:0] w);
         wrap_width = w;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // one written symbol, plus a newline when the line fills up
      function void put_symbol(logic [7:0] sym);
         staged[n_staged] = sym;
         n_staged++;
         line_count = line_count + 8'd1;
         if (line_count >= wrap_width) begin
            line_count = '0;
            staged[n_staged] = NEWLINE_SYM;
            n_staged++;
         end
      endfunction

      // reference symbols are eaten while a deletion is running
      function void put_ref(logic [7:0] sym);
         if (delete_count != 0)
            delete_count = delete_count - 1'b1;
         else
            put_symbol(sym);
      endfunction

      function void close_insertion();
         insert_skip = (pending_ins_len > saved_insert) ? pending_ins_len : saved_insert;
      endfunction

      // lengths arrive at LEN_BITS == COUNT_BITS, so saturation never bites here
      function void note_item(hva_req_type r);
         hva_rsp_type b;
         n_staged = 0;
         case (r.kind)
            KIND_REF: put_ref(r.base);
            KIND_SNP: put_ref(r.present ? r.alt_base : r.base);
            KIND_HDR: begin
               if (!r.same_pos)
                  put_ref(r.base);
               if (r.present) begin
                  if (r.del_len > delete_count)
                     delete_count = r.del_len;
                  if (r.is_insertion) begin
                     overlap_mode    = r.double_ins;
                     saved_insert    = r.double_ins ? insert_skip : '0;
                     pending_ins_len = r.ins_len;
                     if (r.ins_len == 0)
                        close_insertion();
                  end
               end else if (r.clear_ins) begin
                  insert_skip = '0;
               end
            end
            default: begin
               if (overlap_mode && insert_skip != 0)
                  insert_skip = insert_skip - 1'b1;
               else
                  put_symbol(r.base);
               if (r.char_last)
                  close_insertion();
            end
         endcase
         for (int i = 0; i < n_staged; i++) begin
            b.symbol = staged[i];
            b.last   = (i == n_staged - 1);
            expected_q.push_back(b);
         end
      endfunction

      function void check_beat(hva_rsp_type got);
         hva_rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected beat symbol=%02h last=%0b",
                        $time, got.symbol, got.last);
            return;
         end
         want = expected_q.pop_front();
         if (got.symbol !== want.symbol || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("%0t: beat mismatch symbol exp=%02h got=%02h last exp=%0b got=%0b",
                        $time, want.symbol, got.symbol, want.last, got.last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals; every input known from time zero
   // -------------------------------------------------------------------------
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   hva_req_type               req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   hva_rsp_type               rsp_payload;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   logic           quiet = 1'b0;   // last phase: no gaps, no stalls
   int             items_sent = 0;
   int             stall_left = 0;
   hva_scoreboard  sb;

   haplotype_variant_applier u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Result side: stall in random bursts, check every accepted beat.
   // All TB drives are nonblocking at the edge, so sampling here sees the
   // values that were settled before the edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left > 0);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6);
         rsp_stall  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat(rsp_payload);
   end

   // -------------------------------------------------------------------------
   // Item builders: fields that the kind ignores are left random on purpose,
   // which is also how the high bits of the length fields get toggled.
   // -------------------------------------------------------------------------
   function automatic hva_req_type noise_item(hva_kind_type k);
      logic [95:0] bits;
      hva_req_type r;
      bits = {$urandom(), $urandom(), $urandom()};
      r = bits[$bits(hva_req_type)-1:0];
      r.kind = k;
      return r;
   endfunction

   function automatic hva_req_type hdr_item(logic same_pos, logic present, logic [31:0] del,
                                            logic is_ins, logic dbl, logic [31:0] ins,
                                            logic clr);
      hva_req_type r;
      r = noise_item(KIND_HDR);
      r.same_pos     = same_pos;
      r.present      = present;
      r.del_len      = del;
      r.is_insertion = is_ins;
      r.double_ins   = dbl;
      r.ins_len      = ins;
      r.clear_ins    = clr;
      return r;
   endfunction

   function automatic hva_req_type char_item(logic last);
      hva_req_type r;
      r = noise_item(KIND_INS);
      r.char_last = last;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // one item beat; optional idle burst before it, then hold until taken
   task automatic send_item(input hva_req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
      sb.note_item(r);
   endtask

   // setup + access; the write lands on the edge where pready is seen
   task automatic write_wrap_width(input logic [7:0] w);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WRAP_WIDTH_ADDR;
      csr_pwdata  <= {{(CSR_DATA_BITS-8){1'b0}}, w};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_width(w);
   endtask

   // drain all expected beats, then a few cycles for items that wrote nothing
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // one random variant group; mostly well formed, some noise and broken runs
   task automatic send_group();
      hva_req_type r;
      int          n;
      logic        broken;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            repeat ($urandom_range(1, 4)) send_item(noise_item(KIND_REF));
         end
         3: send_item(noise_item(KIND_SNP));
         4: begin
            // plain deletion / SV site
            r = noise_item(KIND_HDR);
            r.present      = 1'b1;
            r.is_insertion = 1'b0;
            r.del_len      = $urandom_range(0, 6);
            send_item(r);
         end
         5, 6: begin
            // insertion, possibly stacked on the previous one
            r = noise_item(KIND_HDR);
            r.present      = 1'b1;
            r.is_insertion = 1'b1;
            r.double_ins   = 1'($urandom_range(0, 1));
            r.same_pos     = r.double_ins ? 1'b1 : 1'($urandom_range(0, 1));
            r.del_len      = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            r.ins_len      = $urandom_range(0, 5);
            broken = ($urandom_range(0, 7) == 0);
            n = broken ? $urandom_range(0, 5) : int'(r.ins_len);
            send_item(r);
            for (int j = 0; j < n; j++)
               send_item(char_item(broken ? 1'($urandom_range(0, 1)) : (j == n - 1)));
         end
         7: begin
            r = noise_item(KIND_HDR);
            r.present = 1'b0;
            send_item(r);
         end
         8: send_item(char_item(1'($urandom_range(0, 1))));
         default: begin
            r = noise_item(hva_kind_type'($urandom_range(0, 3)));
            if (r.kind == KIND_HDR && r.present) begin
               r.del_len = $urandom_range(0, 8);
               r.ins_len = $urandom_range(0, 6);
            end
            send_item(r);
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Run limit
   // -------------------------------------------------------------------------
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      hva_req_type r;
      int          target;
      logic [7:0]  w;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // narrow lines so the directed part sees plenty of newlines
      write_wrap_width(8'd8);

      // extremes of the base fields, SNP chosen and not chosen
      r = noise_item(KIND_REF); r.base = 8'h00; send_item(r);
      r = noise_item(KIND_REF); r.base = 8'hFF; send_item(r);
      r = noise_item(KIND_SNP); r.present = 1'b1; r.base = 8'h00; r.alt_base = 8'hFF;
      send_item(r);
      r = noise_item(KIND_SNP); r.present = 1'b0; r.base = 8'hFF; r.alt_base = 8'h00;
      send_item(r);

      // deletion of two: anchor written, next ref and SNP eaten, then output resumes
      send_item(hdr_item(1'b0, 1'b1, 32'd2, 1'b0, 1'b0, 32'd0, 1'b0));
      send_item(noise_item(KIND_REF));
      r = noise_item(KIND_SNP); r.present = 1'b1; send_item(r);
      send_item(noise_item(KIND_REF));

      // plain insertion of three, leaves a skip count of three
      send_item(hdr_item(1'b0, 1'b1, 32'd0, 1'b1, 1'b0, 32'd3, 1'b0));
      send_item(char_item(1'b0));
      send_item(char_item(1'b0));
      send_item(char_item(1'b1));

      // stacked insertion of five: first three overlap and are skipped
      send_item(hdr_item(1'b1, 1'b1, 32'd0, 1'b1, 1'b1, 32'd5, 1'b0));
      repeat (4) send_item(char_item(1'b0));
      send_item(char_item(1'b1));

      // empty stacked insertion closes at once
      send_item(hdr_item(1'b1, 1'b1, 32'd0, 1'b1, 1'b1, 32'd0, 1'b0));

      // absent allele clears the skip count; a stray character then writes
      send_item(hdr_item(1'b0, 1'b0, $urandom(), 1'b1, 1'b1, $urandom(), 1'b1));
      send_item(char_item(1'b0));

      // full-range insertion length, overlapped, then cleared
      send_item(hdr_item(1'b1, 1'b1, 32'd0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0));
      send_item(char_item(1'b1));
      send_item(hdr_item(1'b1, 1'b1, 32'd0, 1'b1, 1'b1, 32'd2, 1'b0));
      send_item(char_item(1'b0));
      send_item(char_item(1'b1));
      send_item(hdr_item(1'b1, 1'b0, $urandom(), 1'b1, 1'b0, $urandom(), 1'b0));
      send_item(hdr_item(1'b1, 1'b0, $urandom(), 1'b0, 1'b1, $urandom(), 1'b1));
      send_item(char_item(1'b0));
      settle();

      // random phases; the width after 255 lands below the running line count,
      // zero forces a newline after every symbol, the last phase runs flat out
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       w = 8'd1;
            1:       w = 8'd255;
            2:       w = 8'd3;
            3:       w = 8'd0;
            4:       w = WRAP_WIDTH_RESET;
            default: w = 8'($urandom_range(2, 40));
         endcase
         write_wrap_width(w);
         if (p == 5)
            quiet <= 1'b1;
         target = items_sent + 67;
         while (items_sent < target) send_group();
         if (p != 5)
            settle();
      end

      // full-range deletion last: swallows every later reference base,
      // inserted characters still come through
      send_item(hdr_item(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b0));
      repeat (3) send_item(noise_item(KIND_REF));
      send_item(hdr_item(1'b1, 1'b1, 32'd0, 1'b1, 1'b0, 32'd2, 1'b0));
      send_item(char_item(1'b0));
      send_item(char_item(1'b1));

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
